@@ design/sample_dynamics_chain_macros.svh @@
// Assertion macros shared by the sample dynamics chain RTL
`ifndef SAMPLE_DYNAMICS_CHAIN_MACROS_SVH
`define SAMPLE_DYNAMICS_CHAIN_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SDC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sample dynamics chain: implication failed");
// next-cycle implication
`define SDC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sample dynamics chain: next-cycle check failed");
`else
`define SDC_ASSERT_IMP(label, ante, cons)
`define SDC_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ design/sdc_pkg.sv @@
// Shared constants, register codes and soft-clip table builder
package sdc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CLIP_DEPTH_DEF  = 64;
    localparam int ROM_W           = 25;     // table entries, Q.24 with headroom
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int KNEE_LAT        = 3;
    localparam int CLIP_LAT        = 5;

    localparam logic [15:0] PEAK_SLOPE_Q15 = 16'd11469;   // 0.35 in Q1.15

    localparam logic [15:0] GAIN_RST   = 16'd4096;
    localparam logic [14:0] CTHR_RST   = 15'd29205;
    localparam logic [15:0] CSLOPE_RST = 16'd32768;
    localparam logic [15:0] PTHR_RST   = 16'd32768;
    localparam logic [15:0] LTHR_RST   = 16'd32768;
    localparam logic [3:0]  EN_RST     = 4'd0;

    // stage enable bits
    localparam int EN_COMP = 0;
    localparam int EN_PEAK = 1;
    localparam int EN_CLIP = 2;
    localparam int EN_LIM  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN   = 3'd0,
        CFG_CTHR   = 3'd1,
        CFG_CSLOPE = 3'd2,
        CFG_PTHR   = 3'd3,
        CFG_LTHR   = 3'd4,
        CFG_EN     = 3'd5
    } t_cfg_idx;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // tanh(1.75x)/0.94137555 in Q.24 for argument t = 3.5x in Q.30;
    // e^-t by a Taylor series on t/64 then six squarings. Elaboration only.
    function automatic logic [ROM_W-1:0] clip_entry(input logic [63:0] t);
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] f;
        longint      acc;
        s    = t >> 6;
        acc  = longint'(ONE_Q30);
        term = (ONE_Q30 * s) >> 30;         acc = acc - longint'(term);
        term = ((term * s) >> 30) / 2;      acc = acc + longint'(term);
        term = ((term * s) >> 30) / 3;      acc = acc - longint'(term);
        term = ((term * s) >> 30) / 4;      acc = acc + longint'(term);
        term = ((term * s) >> 30) / 5;      acc = acc - longint'(term);
        term = ((term * s) >> 30) / 6;      acc = acc + longint'(term);
        term = ((term * s) >> 30) / 7;      acc = acc - longint'(term);
        term = ((term * s) >> 30) / 8;      acc = acc + longint'(term);
        term = ((term * s) >> 30) / 9;      acc = acc - longint'(term);
        term = ((term * s) >> 30) / 10;     acc = acc + longint'(term);
        term = ((term * s) >> 30) / 11;     acc = acc - longint'(term);
        term = ((term * s) >> 30) / 12;     acc = acc + longint'(term);
        e = (acc > 0) ? 64'(acc) : 64'd0;
        for (int k = 0; k < 6; k++) begin
            e = (e * e + (64'd1 << 29)) >> 30;
        end
        if (e > ONE_Q30) begin
            e = ONE_Q30;
        end
        num = (ONE_Q30 - e) << 30;
        den = ONE_Q30 + e;
        rem = 64'd0;
        quo = 64'd0;
        // shift-subtract quotient
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | {63'd0, num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        f = (quo * 64'd100000000 + 64'd47068777) / 94137555;
        return ROM_W'((f + 64'd32) >> 6);
    endfunction

endpackage

@@ design/sdc_knee.sv @@
// Three-stage knee: above threshold, slope the excess and saturate
module sdc_knee import sdc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_adv,
    input  logic                     i_enable,
    input  logic [SAMPLE_BITS-1:0]   i_thr,
    input  logic [15:0]              i_slope,
    input  logic [SAMPLE_BITS+3:0]   i_v,
    output logic [SAMPLE_BITS+3:0]   o_v
);

    localparam int IW = SAMPLE_BITS + 4;
    localparam int PW = IW + 16;
    localparam int SW = IW + 2;
    localparam int AW = IW + 3;
    localparam logic [IW-1:0] IMAX = '1;

    logic          r1_gt;
    logic [IW-1:0] r1_diff;
    logic [IW-1:0] r1_v;
    logic          r2_gt;
    logic [PW-1:0] r2_prod;
    logic [IW-1:0] r2_v;
    logic [IW-1:0] r3_v;

    logic [SW-1:0] w_step;
    logic [AW-1:0] w_sum;
    logic [IW-1:0] w_sat;

    always_comb begin
        w_step = SW'(((PW+1)'(r2_prod) + (PW+1)'(16384)) >> 15);
        w_sum  = AW'(i_thr) + AW'(w_step);
        w_sat  = (w_sum > AW'(IMAX)) ? IMAX : w_sum[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_gt   <= i_v > IW'(i_thr);
            r1_diff <= i_v - IW'(i_thr);
            r1_v    <= i_v;
            r2_gt   <= r1_gt;
            r2_prod <= PW'(r1_diff) * PW'(i_slope);
            r2_v    <= r1_v;
            r3_v    <= (i_enable && r2_gt) ? w_sat : r2_v;
        end
    end

    assign o_v = r3_v;

endmodule

@@ design/sdc_clip.sv @@
// Five-stage soft clip: table index, registered table read, linear interpolation
module sdc_clip import sdc_pkg::*; #(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int CLIP_TABLE_DEPTH = CLIP_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_adv,
    input  logic                     i_enable,
    input  logic [SAMPLE_BITS+3:0]   i_v,
    output logic [SAMPLE_BITS+3:0]   o_v
);

    localparam int F     = SAMPLE_BITS - 1;
    localparam int IW    = SAMPLE_BITS + 4;
    localparam int IDXW  = $clog2(CLIP_TABLE_DEPTH + 1);
    localparam int PW    = IW + IDXW;
    localparam int FRW   = F + 2;
    localparam int IFW   = PW - FRW;
    localparam int MW    = ROM_W + FRW;
    localparam int YW    = ROM_W + 2;
    localparam int OUT_SH = 24 - F;
    localparam logic [YW-1:0] ROUND = YW'(1) << (23 - F);
    localparam logic [IDXW-1:0] LAST = IDXW'(CLIP_TABLE_DEPTH);

    logic [ROM_W-1:0] w_rom [0:CLIP_TABLE_DEPTH];

    for (genvar gi = 0; gi <= CLIP_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [63:0] T_ARG = (64'd14 << 30) * 64'(gi) / CLIP_TABLE_DEPTH;
        localparam logic [ROM_W-1:0] ENTRY = clip_entry(T_ARG);
        assign w_rom[gi] = ENTRY;
    end

    logic [PW-1:0]    w_p;
    logic [IFW-1:0]   w_idx;
    logic             w_beyond;
    logic [IDXW-1:0]  w_ia;
    logic [IDXW-1:0]  w_ib;
    logic [FRW-1:0]   w_fr;
    logic [YW-1:0]    w_y;

    logic [IDXW-1:0]  r1_ia;
    logic [IDXW-1:0]  r1_ib;
    logic [FRW-1:0]   r1_fr;
    logic [IW-1:0]    r1_v;
    logic [ROM_W-1:0] r2_a;
    logic [ROM_W-1:0] r2_b;
    logic [FRW-1:0]   r2_fr;
    logic [IW-1:0]    r2_v;
    logic [ROM_W-1:0] r3_a;
    logic [ROM_W-1:0] r3_d;
    logic [FRW-1:0]   r3_fr;
    logic [IW-1:0]    r3_v;
    logic [ROM_W-1:0] r4_a;
    logic [MW-1:0]    r4_prod;
    logic [IW-1:0]    r4_v;
    logic [IW-1:0]    r5_v;

    // past the table end: both reads hit the last entry with zero fraction
    always_comb begin
        w_p      = PW'(i_v) * PW'(CLIP_TABLE_DEPTH);
        w_idx    = w_p[PW-1:FRW];
        w_beyond = w_idx >= IFW'(CLIP_TABLE_DEPTH);
        w_ia     = w_beyond ? LAST : w_idx[IDXW-1:0];
        w_ib     = w_beyond ? LAST : w_ia + IDXW'(1);
        w_fr     = w_beyond ? '0 : w_p[FRW-1:0];
        w_y      = YW'(r4_a) + YW'(r4_prod >> FRW) + ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_ia   <= w_ia;
            r1_ib   <= w_ib;
            r1_fr   <= w_fr;
            r1_v    <= i_v;
            r2_a    <= w_rom[r1_ia];
            r2_b    <= w_rom[r1_ib];
            r2_fr   <= r1_fr;
            r2_v    <= r1_v;
            r3_a    <= r2_a;
            r3_d    <= (r2_b >= r2_a) ? r2_b - r2_a : '0;
            r3_fr   <= r2_fr;
            r3_v    <= r2_v;
            r4_a    <= r3_a;
            r4_prod <= MW'(r3_d) * MW'(r3_fr);
            r4_v    <= r3_v;
            r5_v    <= i_enable ? IW'(w_y >> OUT_SH) : r4_v;
        end
    end

    assign o_v = r5_v;

endmodule

@@ design/sample_dynamics_chain.sv @@
// Top level of the sample dynamics chain: gain, compressor, peak cut, soft clip, limiter
// Throughput: one sample per clock; the 15 register stages (gain multiply, two
// three-stage knee units, a five-stage soft clip with registered table read,
// limiter) all advance together and hold as a unit only while the skid is full.
// Reset (i_rst_n low, synchronous): pipeline and output empty, registers at defaults.
`include "sample_dynamics_chain_macros.svh"
module sample_dynamics_chain import sdc_pkg::*; #(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int CLIP_TABLE_DEPTH = CLIP_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    // sample out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    localparam int W      = SAMPLE_BITS;
    localparam int F      = W - 1;
    localparam int IW     = W + 4;          // Q5.F magnitude
    localparam int P2W    = W + 16;
    localparam int THR_SH = 24 - F;
    localparam int DLY    = 2 * KNEE_LAT + CLIP_LAT;
    localparam logic [IW-1:0] FULL = IW'(1) << F;

    // ---------------- configuration registers ----------------
    logic [15:0] r_gain;
    logic [14:0] r_cthr;
    logic [15:0] r_cslope;
    logic [15:0] r_pthr;
    logic [15:0] r_lthr;
    logic [3:0]  r_en;

    // a write takes effect at the edge that accepts it; the port never holds off a request
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RST;
            r_cthr   <= CTHR_RST;
            r_cslope <= CSLOPE_RST;
            r_pthr   <= PTHR_RST;
            r_lthr   <= LTHR_RST;
            r_en     <= EN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN:   r_gain   <= i_cfg_data;
                CFG_CTHR:   r_cthr   <= i_cfg_data[14:0];
                CFG_CSLOPE: r_cslope <= i_cfg_data;
                CFG_PTHR:   r_pthr   <= i_cfg_data;
                CFG_LTHR:   r_lthr   <= i_cfg_data;
                CFG_EN:     r_en     <= i_cfg_data[3:0];
                default:    ;   // unused index, write dropped
            endcase
        end
    end

    // Q1.15 thresholds moved onto the internal fraction width
    logic [W-1:0] w_thr_c;
    logic [W-1:0] w_thr_p;
    logic [W-1:0] w_thr_l;

    always_comb begin
        w_thr_c = W'(({10'd0, r_cthr} << 9) >> THR_SH);
        w_thr_p = W'(({9'd0, r_pthr} << 9) >> THR_SH);
        w_thr_l = W'(({9'd0, r_lthr} << 9) >> THR_SH);
    end

    // ---------------- pipeline control ----------------
    // Every stage moves on together; only a full skid freezes it. Stall to the
    // sender is the registered skid flag, so it never waits on i_out_stall.
    logic r_skid_valid;
    logic w_adv;

    assign w_adv      = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // ---------------- sign split and gain ----------------
    logic           r1_vld;
    logic           r1_neg;
    logic [W-1:0]   r1_mag;
    logic           r2_vld;
    logic           r2_neg;
    logic [P2W-1:0] r2_prod;
    logic           r3_vld;
    logic           r3_neg;
    logic [IW-1:0]  r3_v;

    logic           r_dly_vld [0:DLY-1];
    logic           r_dly_neg [0:DLY-1];

    logic [IW-1:0]  w_comp_v;
    logic [IW-1:0]  w_peak_v;
    logic [IW-1:0]  w_clip_v;

    logic           r_lim_vld;
    logic           r_lim_neg;
    logic [IW-1:0]  r_lim_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r_lim_vld <= 1'b0;
            for (int i = 0; i < DLY; i++) begin
                r_dly_vld[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r1_vld       <= i_in_valid;
            r2_vld       <= r1_vld;
            r3_vld       <= r2_vld;
            r_dly_vld[0] <= r3_vld;
            for (int i = 1; i < DLY; i++) begin
                r_dly_vld[i] <= r_dly_vld[i-1];
            end
            r_lim_vld    <= r_dly_vld[DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // magnitude of the most negative code is 2^(W-1), still W bits
            r1_neg       <= i_sample_in[W-1];
            r1_mag       <= i_sample_in[W-1] ? W'(-i_sample_in) : W'(i_sample_in);
            r2_neg       <= r1_neg;
            r2_prod      <= P2W'(r1_mag) * P2W'(r_gain);
            r3_neg       <= r2_neg;
            r3_v         <= IW'(((P2W+1)'(r2_prod) + (P2W+1)'(2048)) >> 12);
            r_dly_neg[0] <= r3_neg;
            for (int i = 1; i < DLY; i++) begin
                r_dly_neg[i] <= r_dly_neg[i-1];
            end
            // limiter: plain cap at the ceiling
            r_lim_neg    <= r_dly_neg[DLY-1];
            r_lim_v      <= (r_en[EN_LIM] && (w_clip_v > IW'(w_thr_l))) ?
                            IW'(w_thr_l) : w_clip_v;
        end
    end

    // ---------------- dynamics stages ----------------
    // compressor: slope is 1/ratio, result saturates to the internal range
    sdc_knee #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_comp (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_enable (r_en[EN_COMP]),
        .i_thr    (w_thr_c),
        .i_slope  (r_cslope),
        .i_v      (r3_v),
        .o_v      (w_comp_v)
    );

    // peak reduction: fixed slope of 0.35 above its knee
    sdc_knee #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_peak (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_enable (r_en[EN_PEAK]),
        .i_thr    (w_thr_p),
        .i_slope  (PEAK_SLOPE_Q15),
        .i_v      (w_comp_v),
        .o_v      (w_peak_v)
    );

    sdc_clip #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .CLIP_TABLE_DEPTH (CLIP_TABLE_DEPTH)
    ) u_clip (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_enable (r_en[EN_CLIP]),
        .i_v      (w_peak_v),
        .o_v      (w_clip_v)
    );

    // ---------------- sign restore and saturation ----------------
    logic [IW-1:0] w_mag_sat;
    logic [W-1:0]  w_res;

    always_comb begin
        if (r_lim_neg) begin
            w_mag_sat = (r_lim_v > FULL) ? FULL : r_lim_v;
            w_res     = W'(IW'(0) - w_mag_sat);
        end else begin
            w_mag_sat = (r_lim_v > FULL - IW'(1)) ? FULL - IW'(1) : r_lim_v;
            w_res     = w_mag_sat[W-1:0];
        end
    end

    // ---------------- output register and skid ----------------
    // A result leaving the pipe while the output request is held goes to the
    // skid; the pipe then stops until the skid drains into the output.
    logic         r_out_valid;
    logic [W-1:0] r_out_data;
    logic [W-1:0] r_skid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_out_stall) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_valid && i_out_stall) begin
            r_skid_valid <= r_lim_vld;
        end else begin
            r_out_valid <= r_lim_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (!i_out_stall) begin
                r_out_data <= r_skid_data;
            end
        end else if (r_out_valid && i_out_stall) begin
            r_skid_data <= w_res;
        end else begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

    // ---------------- checks ----------------
    `SDC_ASSERT_IMP(a_skid_needs_out, r_skid_valid, r_out_valid)
    `SDC_ASSERT_NXT(a_skid_drains, r_skid_valid && !i_out_stall, r_out_valid && !r_skid_valid)
    `SDC_ASSERT_NXT(a_accept_enters, i_in_valid && !o_in_stall, r1_vld)
    `SDC_ASSERT_IMP(a_lim_ceiling, r_lim_vld && r_en[EN_LIM], r_lim_v <= IW'(w_thr_l))

endmodule

@@ bench/sample_dynamics_chain_test.sv @@
// Self-checking bench for sample_dynamics_chain: directed table, then randomized settings
`timescale 1ns / 100ps
module sample_dynamics_chain_test;
    import sdc_pkg::*;

    localparam int SB         = SAMPLE_BITS_DEF;
    localparam int FB         = SB - 1;
    localparam int DEPTH      = CLIP_DEPTH_DEF;
    localparam int PIPE_DEPTH = 15;        // pipeline depth, sets the drain wait in settle
    localparam int PHASES     = 12;        // random register settings
    localparam int PHASE_LEN  = 92;        // requests per random setting
    localparam int HOLD_AT    = 405;       // result count at which the sink backs off
    localparam int HOLD_LEN   = 120;       // long enough to fill pipe and skid
    localparam int CYCLE_LIMIT = 200000;

    // indexes the block does not decode; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam logic [SB-1:0] S_MIN = {1'b1, {FB{1'b0}}};
    localparam logic [SB-1:0] S_MAX = {1'b0, {FB{1'b1}}};
    localparam logic [63:0]   Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0]   WIDE_MAX = (64'd1 << (FB + 5)) - 64'd1;

    typedef struct {
        logic [15:0] gain;
        logic [15:0] cthr;
        logic [15:0] cslope;
        logic [15:0] pthr;
        logic [15:0] lthr;
        logic [3:0]  en;
    } t_setting;

    // directed row: register setting to use, sample, and a hand-written
    // expectation where one is obvious (typed), else the predictor decides
    typedef struct {
        int              setup;
        logic [SB-1:0]   sample;
        bit              typed;
        logic [SB-1:0]   want;
    } t_probe;

    // setting 0 is the reset state and is never written
    t_setting CFG_SETS [9] = '{
        '{16'd4096,  16'd29205, 16'd32768, 16'd32768, 16'd32768, 4'd0},
        '{16'd65535, 16'd29205, 16'd32768, 16'd32768, 16'd32768, 4'd0},
        '{16'd0,     16'd1036,  16'd1638,  16'd2067,  16'd8230,  4'd15},
        '{16'd65535, 16'd1036,  16'd1638,  16'd2067,  16'd8230,  4'd15},
        '{16'd65535, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  4'd15},
        '{16'd65535, 16'd29205, 16'd32768, 16'd32768, 16'd32768, 4'd4},
        '{16'd16384, 16'd8192,  16'd8192,  16'd32768, 16'd32768, 4'd1},
        '{16'd16384, 16'd29205, 16'd32768, 16'd4096,  16'd32768, 4'd2},
        '{16'd4096,  16'd29205, 16'd32768, 16'd32768, 16'd8230,  4'd8}
    };

    t_probe PROBES [25] = '{
        // reset: unity gain, all stages off, sample passes through
        '{0, 16'sd0,      1'b1, 16'sd0},
        '{0, 16'sd32767,  1'b1, 16'sd32767},
        '{0, 16'sh8000,   1'b1, 16'sh8000},
        '{0, 16'sd1,      1'b1, 16'sd1},
        '{0, -16'sd1,     1'b1, -16'sd1},
        '{0, 16'sd12345,  1'b0, 16'sd0},
        // max gain, no stages: full scale saturates both ways
        '{1, 16'sd32767,  1'b1, 16'sd32767},
        '{1, 16'sh8000,   1'b1, 16'sh8000},
        '{1, 16'sd0,      1'b1, 16'sd0},
        '{1, 16'sd100,    1'b0, 16'sd0},
        // zero gain: everything collapses to zero
        '{2, 16'sd32767,  1'b1, 16'sd0},
        '{2, 16'sh8000,   1'b1, 16'sd0},
        // lowest knees, every stage on
        '{3, 16'sd32767,  1'b0, 16'sd0},
        '{3, 16'sh8000,   1'b0, 16'sd0},
        '{3, 16'sd2000,   1'b0, 16'sd0},
        // all-ones registers: compressor expands and wide value saturates
        '{4, 16'sd32767,  1'b0, 16'sd0},
        '{4, 16'sh8000,   1'b0, 16'sd0},
        '{4, 16'sd9000,   1'b0, 16'sd0},
        // soft clip alone driven past the end of its table
        '{5, 16'sd32767,  1'b0, 16'sd0},
        '{5, 16'sh8000,   1'b0, 16'sd0},
        // single stages
        '{6, 16'sd20000,  1'b0, 16'sd0},
        '{6, -16'sd3000,  1'b0, 16'sd0},
        '{7, 16'sd10000,  1'b0, 16'sd0},
        '{8, 16'sd30000,  1'b0, 16'sd0},
        '{8, -16'sd30000, 1'b0, 16'sd0}
    };

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic signed [SB-1:0] i_sample_in  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic signed [SB-1:0] o_sample_out;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;

    // shadow copy of the register file, as the block should hold it
    logic [15:0] sh_gain   = GAIN_RST;
    logic [14:0] sh_cthr   = CTHR_RST;
    logic [15:0] sh_cslope = CSLOPE_RST;
    logic [15:0] sh_pthr   = PTHR_RST;
    logic [15:0] sh_lthr   = LTHR_RST;
    logic [3:0]  sh_en     = EN_RST;

    logic [63:0]   tanh_lut [0:DEPTH];    // soft-clip curve, Q.24
    logic [SB-1:0] due_samples [$];       // outputs still owed by the block

    int sent;
    int got;
    int errors;
    int setups_applied;
    int cycles;

    sample_dynamics_chain uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Soft-clip curve tanh(1.75x)/0.94137555 at x = 4i/DEPTH, integer only.
    // e^-t is a series to order 12 on t/64, squared six times.
    initial begin : build_tanh_lut
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] th;
        logic [63:0] f;
        longint      acc;
        for (int i = 0; i <= DEPTH; i++) begin
            t    = (64'd14 << 30) * 64'(i) / 64'(DEPTH);
            s    = t >> 6;
            term = Q30_ONE;
            acc  = longint'(Q30_ONE);
            for (int k = 1; k <= 12; k++) begin
                term = ((term * s) >> 30) / 64'(k);
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            e = (acc > 0) ? 64'(acc) : 64'd0;
            for (int k = 0; k < 6; k++) begin
                e = (e * e + (64'd1 << 29)) >> 30;
            end
            if (e > Q30_ONE) begin
                e = Q30_ONE;
            end
            th = ((Q30_ONE - e) << 30) / (Q30_ONE + e);
            f  = (th * 64'd100000000 + 64'd47068777) / 64'd94137555;
            tanh_lut[i] = (f + 64'd32) >> 6;
        end
    end

    // Q1.15 register to the wide internal scale
    function automatic logic [63:0] knee(input logic [63:0] r);
        return (r << 9) >> (24 - FB);
    endfunction

    // What the chain should produce for one sample under the shadow registers.
    function automatic logic [SB-1:0] dynamics_out(input logic [SB-1:0] s);
        logic [63:0] mag;
        logic [63:0] v;
        logic [63:0] thr;
        logic [63:0] full;
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] fr;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] y;
        bit          neg;
        neg  = s[SB-1];
        mag  = neg ? ((64'd1 << SB) - 64'(s)) : 64'(s);
        v    = (mag * 64'(sh_gain) + 64'd2048) >> 12;
        full = 64'd1 << FB;
        if (sh_en[EN_COMP]) begin
            thr = knee(64'(sh_cthr));
            if (v > thr) begin
                v = thr + (((v - thr) * 64'(sh_cslope) + 64'd16384) >> 15);
            end
            if (v > WIDE_MAX) begin
                v = WIDE_MAX;
            end
        end
        if (sh_en[EN_PEAK]) begin
            thr = knee(64'(sh_pthr));
            if (v > thr) begin
                v = thr + (((v - thr) * 64'(PEAK_SLOPE_Q15) + 64'd16384) >> 15);
            end
        end
        if (sh_en[EN_CLIP]) begin
            p   = v * 64'(DEPTH);
            idx = p >> (FB + 2);
            fr  = p & ((64'd1 << (FB + 2)) - 64'd1);
            if (idx >= 64'(DEPTH)) begin
                // past the table the last entry holds flat
                y = tanh_lut[DEPTH];
            end else begin
                a = tanh_lut[idx];
                b = tanh_lut[idx + 1];
                y = a + ((((b >= a) ? b - a : 64'd0) * fr) >> (FB + 2));
            end
            v = (y + (64'd1 << (23 - FB))) >> (24 - FB);
        end
        if (sh_en[EN_LIM]) begin
            thr = knee(64'(sh_lthr));
            if (v > thr) begin
                v = thr;
            end
        end
        // sign back on, saturate to the sample range (zero counts as positive)
        if (neg) begin
            if (v > full) begin
                v = full;
            end
            return SB'((64'd1 << SB) - v);
        end else begin
            if (v > full - 64'd1) begin
                v = full - 64'd1;
            end
            return SB'(v);
        end
    endfunction

    // idle cycles before the next request; zero throughout quiet stretches
    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 4));
    endfunction

    // one register write; the shadow follows at the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_GAIN:   sh_gain   = data;
            CFG_CTHR:   sh_cthr   = data[14:0];
            CFG_CSLOPE: sh_cslope = data;
            CFG_PTHR:   sh_pthr   = data;
            CFG_LTHR:   sh_lthr   = data;
            CFG_EN:     sh_en     = data[3:0];
            default:    ;
        endcase
    endtask

    // full register file plus writes to undecoded slots; valid drops only at the end
    task automatic apply_setting(input t_setting c);
        write_reg(CFG_GAIN,    c.gain);
        write_reg(CFG_CTHR,    c.cthr);
        write_reg(CFG_CSLOPE,  c.cslope);
        write_reg(CFG_PTHR,    c.pthr);
        write_reg(CFG_LTHR,    c.lthr);
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_EN,      {12'd0, c.en});
        write_reg(CFG_SPARE_B, 16'h0000);
        i_cfg_valid <= 1'b0;
        setups_applied++;
    endtask

    // stop offering, let every owed result come out, then let the pipe empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_samples.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    // offer one sample; on acceptance record what must come out for it
    task automatic push_sample(input logic [SB-1:0] s, input bit typed,
                               input logic [SB-1:0] want);
        int gap;
        gap = draw_wait((sent / 80) % 4 == 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        due_samples.insert(due_samples.size(), typed ? want : dynamics_out(s));
        sent++;
    endtask

    // Sink: random back-pressure, one long hold-off to fill the pipe, and
    // an in-order compare of every delivered sample.
    initial begin : sample_sink
        int            hold;
        logic [SB-1:0] exp_sample;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = (got == HOLD_AT) ? HOLD_LEN : draw_wait((got / 70) % 4 == 1);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (due_samples.size() == 0) begin
                $error("sample_out: no result expected, actual %0d", o_sample_out);
                errors++;
            end else begin
                exp_sample = due_samples.pop_front();
                if (o_sample_out !== exp_sample) begin
                    $error("sample_out: expected %0d, actual %0d",
                           $signed(exp_sample), o_sample_out);
                    errors++;
                end
            end
            got++;
        end
    end

    // Source: reset, directed table, then random settings with random samples.
    initial begin : stimulus
        int       cur_setup;
        int       small_mag;
        t_setting cfg;
        logic [SB-1:0] smp;
        cur_setup = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; registers change only with the pipe drained
        for (int r = 0; r < $size(PROBES); r++) begin
            if (PROBES[r].setup != cur_setup) begin
                settle();
                apply_setting(CFG_SETS[PROBES[r].setup]);
                cur_setup = PROBES[r].setup;
            end
            push_sample(PROBES[r].sample, PROBES[r].typed, PROBES[r].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            // mostly in-range registers; now and then a full-width value,
            // and every fourth phase one of the extreme corners
            if (ph % 4 == 3) begin
                cfg = CFG_SETS[$urandom_range(3, 4)];
            end else begin
                case ($urandom_range(0, 3))
                    0:       cfg.gain = 16'd4096;
                    1:       cfg.gain = 16'($urandom_range(0, 65535));
                    2:       cfg.gain = 16'($urandom_range(2048, 16384));
                    default: cfg.gain = 16'($urandom_range(4096, 40000));
                endcase
                cfg.cthr   = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(1036, 29205));
                cfg.cslope = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(1638, 32768));
                cfg.pthr   = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(2067, 32768));
                cfg.lthr   = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(8230, 32768));
            end
            cfg.en = 4'($urandom_range(0, 15));
            settle();
            apply_setting(cfg);

            for (int k = 0; k < PHASE_LEN; k++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        case ($urandom_range(0, 5))
                            0:       smp = S_MIN;
                            1:       smp = S_MAX;
                            2:       smp = '0;
                            3:       smp = SB'(1);
                            4:       smp = '1;
                            default: smp = S_MIN + SB'(1);
                        endcase
                    end
                    1, 2: begin
                        small_mag = $urandom_range(0, 2047);
                        smp = $urandom_range(0, 1) ? SB'(-small_mag) : SB'(small_mag);
                    end
                    default: smp = SB'($urandom);
                endcase
                push_sample(smp, 1'b0, '0);
            end
        end

        settle();
        $display("Sent %0d samples through %0d register settings (all stages, corners)",
                 sent, setups_applied);
        $display("Checked %0d outputs, %0d mismatches", got, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/sdc_pkg.sv
design/sdc_knee.sv
design/sdc_clip.sv
design/sample_dynamics_chain.sv
bench/sample_dynamics_chain_test.sv
